// ===== rtl/core/hgp_pkg.sv =====
// shared constants, types and command and status structs of the hypergeometric probability core
`timescale 1ns / 1ps

package hgp_pkg;

  localparam int CNT_W          = 10;
  localparam int ACC_W          = 64;
  localparam int FRACTION_BITS  = 47;
  localparam int PROB_W         = 48;
  localparam int STATUS_W       = 2;
  localparam int PROD_W         = ACC_W + CNT_W;
  localparam int MAX_POPULATION = 1023;
  localparam int DIV_CNT_W      = $clog2(ACC_W);
  localparam int IN_DATA_W      = 4 * CNT_W;
  localparam int OUT_DATA_W     = PROB_W;

  localparam logic [ACC_W-1:0] ACC_ONE =
    {{(ACC_W-FRACTION_BITS-1){1'b0}}, 1'b1, {FRACTION_BITS{1'b0}}};

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_SATURATED = 2'd2
  } status_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic div;
    logic commit;
    logic mark_invalid;
    logic mark_sat;
  } hgp_cmd_t;

  typedef struct packed {
    logic counts_bad;
    logic steps_done;
    logic ovf;
    logic last_iter;
  } hgp_stat_t;

endpackage

// ===== rtl/core/hgp_dpath.sv =====
// datapath: request registers, accumulator, multiplier and radix-2 divider
`timescale 1ns / 1ps

module hgp_dpath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [hgp_pkg::IN_DATA_W-1:0] req_i,
  input  hgp_pkg::hgp_cmd_t            cmd_i,
  output hgp_pkg::hgp_stat_t           stat_o,
  output logic [hgp_pkg::PROB_W-1:0]   prob_o,
  output hgp_pkg::status_t             status_o
);
  import hgp_pkg::*;

  logic [CNT_W-1:0]     pn_r, pk_r, sn_r, sk_r;
  logic [CNT_W-1:0]     i_r;
  logic                 pass_r;
  logic [ACC_W-1:0]     acc_r;
  logic [CNT_W-1:0]     rem_r;
  logic [ACC_W-1:0]     q_r;
  logic [CNT_W-1:0]     den_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  status_t              status_r;

  logic [CNT_W-1:0]     j;
  logic [CNT_W-1:0]     num;
  logic [CNT_W-1:0]     den;
  logic [PROD_W-1:0]    prod;
  logic [CNT_W:0]       trial;
  logic [CNT_W:0]       diff;
  logic                 ge;

  assign j = i_r - sk_r;

  // sample ratio on the first pass, population ratio on the second
  always_comb begin
    if (pass_r) begin
      num = pk_r - i_r;
      den = pn_r - i_r;
    end else if (i_r < sk_r) begin
      num = sn_r - i_r;
      den = sk_r - i_r;
    end else begin
      num = (pn_r - sn_r) - j;
      den = (pk_r - sk_r) - j;
    end
  end

  assign prod  = {{CNT_W{1'b0}}, acc_r} * {{ACC_W{1'b0}}, num};
  assign trial = {rem_r, q_r[ACC_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  assign stat_o.counts_bad = (pn_r > CNT_W'(MAX_POPULATION)) || (pk_r > pn_r) ||
                             (sn_r > pn_r) || (sk_r > sn_r) || (sk_r > pk_r) ||
                             ((sn_r - sk_r) > (pn_r - pk_r));
  assign stat_o.steps_done = (i_r == pk_r);
  assign stat_o.ovf        = (rem_r >= den_r);
  assign stat_o.last_iter  = (cnt_r == DIV_CNT_W'(ACC_W - 1));

  assign prob_o   = (status_r == ST_OK) ? acc_r[PROB_W-1:0] : '0;
  assign status_o = status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r      <= '0;
      pass_r   <= 1'b0;
      cnt_r    <= '0;
      status_r <= ST_OK;
    end else begin
      if (cmd_i.load) begin
        i_r      <= '0;
        pass_r   <= 1'b0;
        status_r <= ST_OK;
      end
      if (cmd_i.mul) begin
        cnt_r <= '0;
      end
      if (cmd_i.div) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd_i.commit) begin
        if (pass_r) begin
          pass_r <= 1'b0;
          i_r    <= i_r + 1'b1;
        end else begin
          pass_r <= 1'b1;
        end
      end
      if (cmd_i.mark_invalid) begin
        status_r <= ST_INVALID;
      end
      if (cmd_i.mark_sat) begin
        status_r <= ST_SATURATED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      pn_r  <= req_i[CNT_W-1:0];
      pk_r  <= req_i[2*CNT_W-1:CNT_W];
      sn_r  <= req_i[3*CNT_W-1:2*CNT_W];
      sk_r  <= req_i[4*CNT_W-1:3*CNT_W];
      acc_r <= ACC_ONE;
    end
    if (cmd_i.mul) begin
      rem_r <= prod[PROD_W-1:ACC_W];
      q_r   <= prod[ACC_W-1:0];
      den_r <= den;
    end
    if (cmd_i.div) begin
      rem_r <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      q_r   <= {q_r[ACC_W-2:0], ge};
    end
    if (cmd_i.commit) begin
      acc_r <= q_r;
    end
    if (cmd_i.mark_sat) begin
      acc_r <= '1;
    end
  end

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.div |-> (rem_r < den_r))
    else $error("divider remainder not below divisor");

  a_mul_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.mul |-> (i_r < pk_r) && (den != '0))
    else $error("multiply issued past the last step or with zero divisor");

endmodule

// ===== rtl/core/hgp_ctrl.sv =====
// controller state machine sequencing steps, multiplies and divider iterations
`timescale 1ns / 1ps

module hgp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               out_free_i,
  input  hgp_pkg::hgp_stat_t stat_i,
  output hgp_pkg::hgp_cmd_t  cmd_o,
  output logic               publish_o
);
  import hgp_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_CHECK  = 7'b0000010,
    S_MUL    = 7'b0000100,
    S_OVF    = 7'b0001000,
    S_DIV    = 7'b0010000,
    S_COMMIT = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd_o      = '0;
    publish_o  = 1'b0;
    in_ready_o = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready_o = rst_n;
        if (in_valid_i && rst_n) begin
          cmd_o.load = 1'b1;
          state_nxt  = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (stat_i.counts_bad) begin
          cmd_o.mark_invalid = 1'b1;
          state_nxt          = S_DONE;
        end else if (stat_i.steps_done) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_nxt = S_OVF;
      end
      S_OVF: begin
        if (stat_i.ovf) begin
          cmd_o.mark_sat = 1'b1;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div = 1'b1;
        if (stat_i.last_iter) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_nxt    = S_CHECK;
      end
      S_DONE: begin
        if (out_free_i) begin
          publish_o = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd_o.load, cmd_o.mul, cmd_o.div, cmd_o.commit,
              cmd_o.mark_invalid, cmd_o.mark_sat, publish_o}))
    else $error("more than one datapath command at once");

  a_div_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> !stat_i.ovf)
    else $error("divider running on an overflowing product");

endmodule

// ===== rtl/core/hypergeometric_probability_core.sv =====
// top level of the hypergeometric probability core
//
//  channel | dir | fields (lowest bit first)
//  in_     | in  | tdata: population_size, population_successes, sample_size,
//          |     |        sample_successes (10 bits each)
//  out_    | out | tdata: probability (48); tuser: status (2)
//
// one request at a time; each step runs two multiply-divides, each made of a
// multiply, an overflow check, 64 divider iterations, a commit and a check,
// and a request runs K steps, K the population successes
// synchronous active-low reset returns to idle with the output empty
// a new request is taken while a finished result waits in the output register
`timescale 1ns / 1ps

module hypergeometric_probability_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [hgp_pkg::IN_DATA_W-1:0]  in_tdata,  // N, K, n, k
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [hgp_pkg::OUT_DATA_W-1:0] out_tdata, // probability
  output logic [hgp_pkg::STATUS_W-1:0]   out_tuser  // status
);
  import hgp_pkg::*;

  hgp_cmd_t            cmd;
  hgp_stat_t           stat;
  logic                publish;
  logic                out_free;
  logic [PROB_W-1:0]   prob;
  status_t             status;

  logic                out_valid_r;
  logic [PROB_W-1:0]   out_prob_r;
  logic [STATUS_W-1:0] out_status_r;

  assign out_free = !out_valid_r || out_tready;

  hgp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid_i (in_tvalid),
    .in_ready_o (in_tready),
    .out_free_i (out_free),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .publish_o  (publish)
  );

  hgp_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_i    (in_tdata),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .prob_o   (prob),
    .status_o (status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (publish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (publish) begin
      out_prob_r   <= prob;
      out_status_r <= status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_prob_r;
  assign out_tuser  = out_status_r;

  a_publish_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    publish |-> (!out_valid_r || out_tready))
    else $error("result written over an untaken result");

endmodule
